### hdl/rtlu_pkg.sv
package rtlu_pkg;

    localparam int ADDR_W = 8;
    localparam int COST_W = 8;
    localparam int SLOT_W = 6;
    localparam int STATUS_W = 3;
    localparam int NOW_W = 32;

    // command codes
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // configuration register indexes
    localparam logic CFG_OWN_ADDRESS = 1'b0;
    localparam logic CFG_INFINITE_COST = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_NEW = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALIDATED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNCHANGED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SELF = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FOUND = 3'd6;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd7;

    // one route as held in the route memory
    typedef struct packed {
        logic [ADDR_W-1:0] dst;
        logic [ADDR_W-1:0] hop;
        logic [COST_W-1:0] cost;
    } route_t;

    // controller to table strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_valid;
        logic wr_time;
    } tbl_ctl_t;

endpackage

### hdl/rtlu_table.sv
module rtlu_table #(
    parameter int TABLE_ENTRIES = 64,
    parameter int TIME_BITS = 32,
    localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rtlu_pkg::tbl_ctl_t     ctl,
    input  logic [IDX_W-1:0]       addr,
    input  rtlu_pkg::route_t       wr_route,
    input  logic [TIME_BITS-1:0]   wr_time,
    output rtlu_pkg::route_t       rd_route,
    output logic                   rd_valid
);

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic                     rd_valid_reg;
    rtlu_pkg::route_t         rd_route_reg;
    rtlu_pkg::route_t         route_mem [TABLE_ENTRIES];
    logic [TIME_BITS-1:0]     time_mem [TABLE_ENTRIES];

    // valid bits in flops: cleared at once by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[addr] <= ctl.wr_valid;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            route_mem[addr] <= wr_route;
        end
        if (ctl.rd_en)
        begin
            rd_route_reg <= route_mem[addr];
        end
    end

    // timestamps: kept on invalidation, so separate enable
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en && ctl.wr_time)
        begin
            time_mem[addr] <= wr_time;
        end
    end

    assign rd_route = rd_route_reg;
    assign rd_valid = rd_valid_reg;

endmodule

### hdl/rtlu_ctrl.sv
module rtlu_ctrl #(
    parameter int TABLE_ENTRIES = 64,
    parameter int TIME_BITS = 32,
    localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [rtlu_pkg::ADDR_W-1:0]         destination,
    input  logic [rtlu_pkg::ADDR_W-1:0]         via_hop,
    input  logic [rtlu_pkg::COST_W-1:0]         path_cost,
    input  logic [rtlu_pkg::NOW_W-1:0]          now_time,
    input  logic [rtlu_pkg::ADDR_W-1:0]         own_address,
    input  logic [rtlu_pkg::COST_W-1:0]         infinite_cost,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [rtlu_pkg::STATUS_W-1:0]       status,
    output logic [rtlu_pkg::SLOT_W-1:0]         slot,
    output logic [rtlu_pkg::ADDR_W-1:0]         route_next_hop,
    output logic [rtlu_pkg::COST_W-1:0]         route_cost,
    output rtlu_pkg::tbl_ctl_t                  tbl_ctl,
    output logic [IDX_W-1:0]                    tbl_addr,
    output rtlu_pkg::route_t                    tbl_wr_route,
    output logic [TIME_BITS-1:0]                tbl_wr_time,
    input  rtlu_pkg::route_t                    tbl_rd_route,
    input  logic                                tbl_rd_valid
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE} state_t;

    state_t                          state_reg;
    logic                            issuing_reg;
    logic [IDX_W-1:0]                issue_idx_reg;
    logic                            pend_reg;
    logic [IDX_W-1:0]                pend_idx_reg;
    logic                            cmd_reg;
    logic [rtlu_pkg::ADDR_W-1:0]     dst_reg;
    logic [rtlu_pkg::ADDR_W-1:0]     hop_reg;
    logic [rtlu_pkg::COST_W-1:0]     cost_reg;
    logic [TIME_BITS-1:0]            now_reg;
    logic                            m_found_reg;
    logic [IDX_W-1:0]                m_idx_reg;
    logic [rtlu_pkg::ADDR_W-1:0]     m_hop_reg;
    logic [rtlu_pkg::COST_W-1:0]     m_cost_reg;
    logic                            f_found_reg;
    logic [IDX_W-1:0]                f_idx_reg;
    logic                            out_valid_reg;
    logic [rtlu_pkg::STATUS_W-1:0]   status_reg;
    logic [rtlu_pkg::SLOT_W-1:0]     slot_reg;
    logic [rtlu_pkg::ADDR_W-1:0]     res_hop_reg;
    logic [rtlu_pkg::COST_W-1:0]     res_cost_reg;

    logic [TIME_BITS+rtlu_pkg::NOW_W-1:0] now_ext;
    logic                                 accept;
    logic                                 hit;
    logic                                 empty;
    logic                                 fire;

    logic                            d_write;
    logic                            d_valid;
    logic                            d_time;
    logic                            d_has;
    logic [IDX_W-1:0]                d_idx;
    rtlu_pkg::route_t                d_route;
    logic [rtlu_pkg::STATUS_W-1:0]   d_status;
    logic [rtlu_pkg::ADDR_W-1:0]     d_hop;
    logic [rtlu_pkg::COST_W-1:0]     d_cost;
    logic [IDX_W+rtlu_pkg::SLOT_W-1:0] d_slot_ext;

    assign now_ext = {{TIME_BITS{1'b0}}, now_time};
    assign accept = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    // read data belongs to pend_idx_reg
    assign hit = pend_reg && tbl_rd_valid && (tbl_rd_route.dst == dst_reg);
    assign empty = pend_reg && !tbl_rd_valid;

    assign fire = !out_valid_reg || !out_stall;

    always_comb
    begin
        d_write = 1'b0;
        d_valid = 1'b1;
        d_time = 1'b0;
        d_has = m_found_reg;
        d_idx = m_idx_reg;
        d_route = '{dst: dst_reg, hop: hop_reg, cost: cost_reg};
        d_status = rtlu_pkg::ST_UNCHANGED;
        d_hop = m_hop_reg;
        d_cost = m_cost_reg;
        if (cmd_reg == rtlu_pkg::CMD_LOOKUP)
        begin
            d_status = m_found_reg ? rtlu_pkg::ST_FOUND : rtlu_pkg::ST_NOT_FOUND;
        end
        else if (dst_reg == own_address)
        begin
            if (m_found_reg || f_found_reg)
            begin
                d_has = 1'b1;
                d_idx = m_found_reg ? m_idx_reg : f_idx_reg;
                d_write = 1'b1;
                d_time = 1'b1;
                d_route = '{dst: own_address, hop: own_address, cost: '0};
                d_status = rtlu_pkg::ST_SELF;
                d_hop = own_address;
                d_cost = '0;
            end
            else
            begin
                d_status = rtlu_pkg::ST_FULL;
            end
        end
        else if (!m_found_reg)
        begin
            if (f_found_reg)
            begin
                d_has = 1'b1;
                d_idx = f_idx_reg;
                d_write = 1'b1;
                d_time = 1'b1;
                d_status = rtlu_pkg::ST_NEW;
                d_hop = hop_reg;
                d_cost = cost_reg;
            end
            else
            begin
                d_status = rtlu_pkg::ST_FULL;
            end
        end
        else if ((m_hop_reg != hop_reg) || (m_cost_reg != cost_reg))
        begin
            d_write = 1'b1;
            if (cost_reg >= infinite_cost)
            begin
                // drop the route, keep hop and timestamp
                d_valid = 1'b0;
                d_route = '{dst: dst_reg, hop: m_hop_reg, cost: infinite_cost};
                d_status = rtlu_pkg::ST_INVALIDATED;
                d_cost = infinite_cost;
            end
            else
            begin
                d_time = 1'b1;
                d_status = rtlu_pkg::ST_UPDATED;
                d_hop = hop_reg;
                d_cost = cost_reg;
            end
        end
    end

    assign d_slot_ext = {{rtlu_pkg::SLOT_W{1'b0}}, d_idx};

    assign tbl_ctl.rd_en = (state_reg == S_SCAN) && issuing_reg;
    assign tbl_ctl.wr_en = (state_reg == S_DECIDE) && fire && d_write;
    assign tbl_ctl.wr_valid = d_valid;
    assign tbl_ctl.wr_time = d_time;
    assign tbl_addr = (state_reg == S_DECIDE) ? d_idx : issue_idx_reg;
    assign tbl_wr_route = d_route;
    assign tbl_wr_time = now_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            issuing_reg <= 1'b0;
            issue_idx_reg <= '0;
            pend_reg <= 1'b0;
            pend_idx_reg <= '0;
            cmd_reg <= rtlu_pkg::CMD_UPDATE;
            dst_reg <= '0;
            hop_reg <= '0;
            cost_reg <= '0;
            now_reg <= '0;
            m_found_reg <= 1'b0;
            m_idx_reg <= '0;
            m_hop_reg <= '0;
            m_cost_reg <= '0;
            f_found_reg <= 1'b0;
            f_idx_reg <= '0;
            out_valid_reg <= 1'b0;
            status_reg <= '0;
            slot_reg <= '0;
            res_hop_reg <= '0;
            res_cost_reg <= '0;
        end
        else
        begin
            // new result wins over the hand-off of the old one
            if ((state_reg == S_DECIDE) && fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg <= command;
                        dst_reg <= destination;
                        hop_reg <= via_hop;
                        cost_reg <= path_cost;
                        now_reg <= now_ext[TIME_BITS-1:0];
                        issuing_reg <= 1'b1;
                        issue_idx_reg <= '0;
                        pend_reg <= 1'b0;
                        m_found_reg <= 1'b0;
                        f_found_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    pend_reg <= issuing_reg;
                    pend_idx_reg <= issue_idx_reg;
                    if (issuing_reg)
                    begin
                        if (issue_idx_reg == LAST_IDX)
                        begin
                            issuing_reg <= 1'b0;
                        end
                        else
                        begin
                            issue_idx_reg <= issue_idx_reg + 1'b1;
                        end
                    end
                    // first valid match and first free slot
                    if (hit && !m_found_reg)
                    begin
                        m_found_reg <= 1'b1;
                        m_idx_reg <= pend_idx_reg;
                        m_hop_reg <= tbl_rd_route.hop;
                        m_cost_reg <= tbl_rd_route.cost;
                    end
                    if (empty && !f_found_reg)
                    begin
                        f_found_reg <= 1'b1;
                        f_idx_reg <= pend_idx_reg;
                    end
                    if (pend_reg && (pend_idx_reg == LAST_IDX))
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    if (fire)
                    begin
                        status_reg <= d_status;
                        slot_reg <= d_has ? d_slot_ext[rtlu_pkg::SLOT_W-1:0] : '0;
                        res_hop_reg <= d_has ? d_hop : '0;
                        res_cost_reg <= d_has ? d_cost : '0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign slot = slot_reg;
    assign route_next_hop = res_hop_reg;
    assign route_cost = res_cost_reg;

endmodule

### hdl/routing_table_update_lookup_unit.sv
// A transaction is latched, scanned against every table entry and then decided; its result
// is registered as it is decided. The next transaction is taken only after that, a pace set
// by the full-table scan through the single read port of the route memory, one entry per cycle.
// A finished result waits in the output register while the next transaction is taken.
// Reset (rst_n, async, active low): all routes invalid at once, own_address 0,
// infinite_cost 16; no clearing pass, the block is ready right after reset.
module routing_table_update_lookup_unit #(
    parameter int TABLE_ENTRIES = 64,
    parameter int TIME_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [rtlu_pkg::ADDR_W-1:0]       cfg_data,
    // input transactions
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              command,
    input  logic [rtlu_pkg::ADDR_W-1:0]       destination,
    input  logic [rtlu_pkg::ADDR_W-1:0]       via_hop,
    input  logic [rtlu_pkg::COST_W-1:0]       path_cost,
    input  logic [rtlu_pkg::NOW_W-1:0]        now_time,
    // result transactions
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [rtlu_pkg::STATUS_W-1:0]     status,
    output logic [rtlu_pkg::SLOT_W-1:0]       slot,
    output logic [rtlu_pkg::ADDR_W-1:0]       route_next_hop,
    output logic [rtlu_pkg::COST_W-1:0]       route_cost
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic [rtlu_pkg::ADDR_W-1:0] own_address_reg;
    logic [rtlu_pkg::COST_W-1:0] infinite_cost_reg;

    rtlu_pkg::tbl_ctl_t   tbl_ctl;
    logic [IDX_W-1:0]     tbl_addr;
    rtlu_pkg::route_t     tbl_wr_route;
    logic [TIME_BITS-1:0] tbl_wr_time;
    rtlu_pkg::route_t     tbl_rd_route;
    logic                 tbl_rd_valid;

    // Configuration registers. Write only while no transaction is in flight; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg <= '0;
            infinite_cost_reg <= 8'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rtlu_pkg::CFG_OWN_ADDRESS:   own_address_reg <= cfg_data;
                rtlu_pkg::CFG_INFINITE_COST: infinite_cost_reg <= cfg_data;
                default:                     own_address_reg <= own_address_reg;
            endcase
        end
    end

    // Controller: latches the transaction, streams every slot out of the table,
    // keeps the first valid match and the first free slot, then decides and
    // does at most one write-back in the same cycle the result is registered.
    // Scan and write-back never overlap, so no forwarding is needed.
    rtlu_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .TIME_BITS     (TIME_BITS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .destination    (destination),
        .via_hop        (via_hop),
        .path_cost      (path_cost),
        .now_time       (now_time),
        .own_address    (own_address_reg),
        .infinite_cost  (infinite_cost_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .slot           (slot),
        .route_next_hop (route_next_hop),
        .route_cost     (route_cost),
        .tbl_ctl        (tbl_ctl),
        .tbl_addr       (tbl_addr),
        .tbl_wr_route   (tbl_wr_route),
        .tbl_wr_time    (tbl_wr_time),
        .tbl_rd_route   (tbl_rd_route),
        .tbl_rd_valid   (tbl_rd_valid)
    );

    // Route table: synchronous route and timestamp memories plus valid flops.
    rtlu_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .TIME_BITS     (TIME_BITS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (tbl_ctl),
        .addr     (tbl_addr),
        .wr_route (tbl_wr_route),
        .wr_time  (tbl_wr_time),
        .rd_route (tbl_rd_route),
        .rd_valid (tbl_rd_valid)
    );

endmodule

### hdl/rtlu_checker.sv
module rtlu_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [rtlu_pkg::STATUS_W-1:0] status,
    input logic [rtlu_pkg::SLOT_W-1:0]   slot,
    input logic [rtlu_pkg::ADDR_W-1:0]   route_next_hop,
    input logic [rtlu_pkg::COST_W-1:0]   route_cost
);

    // one transaction at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a transaction is in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot))
        else $error("stalled result changed");

    a_no_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == rtlu_pkg::ST_FULL || status == rtlu_pkg::ST_NOT_FOUND)
        |-> slot == '0 && route_next_hop == '0 && route_cost == '0)
        else $error("full or not found result carries a route");

    a_self_cost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == rtlu_pkg::ST_SELF |-> route_cost == '0)
        else $error("self route with nonzero cost");

endmodule

bind routing_table_update_lookup_unit rtlu_checker u_rtlu_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .slot           (slot),
    .route_next_hop (route_next_hop),
    .route_cost     (route_cost)
);

### bench/routing_table_update_lookup_unit_test.sv
`timescale 1ns / 100ps

module routing_table_update_lookup_unit_test;

    localparam int TABLE_ENTRIES = 64;
    localparam int TIME_BITS = 32;
    localparam int LATENCY = TABLE_ENTRIES + 2;
    localparam int SETTLE_CYCLES = LATENCY + 8;
    localparam int HOLD_CYCLES = 800;
    // slowest clean run is roughly 1800 transactions, each a full-table scan, plus stalls
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                        command;
        logic [rtlu_pkg::ADDR_W-1:0] destination;
        logic [rtlu_pkg::ADDR_W-1:0] via_hop;
        logic [rtlu_pkg::COST_W-1:0] path_cost;
        logic [rtlu_pkg::NOW_W-1:0]  now_time;
    } route_request_t;

    typedef struct packed {
        logic [rtlu_pkg::STATUS_W-1:0] status;
        logic [rtlu_pkg::SLOT_W-1:0]   slot;
        logic [rtlu_pkg::ADDR_W-1:0]   hop;
        logic [rtlu_pkg::COST_W-1:0]   cost;
    } route_result_t;

    // Shadow route table plus the queue of results still owed by the block.
    // Timestamps never reach the result port, so they are not kept here.
    class route_scoreboard;
        bit                        entry_used [TABLE_ENTRIES];
        bit [rtlu_pkg::ADDR_W-1:0] entry_dst  [TABLE_ENTRIES];
        bit [rtlu_pkg::ADDR_W-1:0] entry_hop  [TABLE_ENTRIES];
        bit [rtlu_pkg::COST_W-1:0] entry_cost [TABLE_ENTRIES];
        bit [rtlu_pkg::ADDR_W-1:0] own_addr;
        bit [rtlu_pkg::COST_W-1:0] cost_limit;
        route_result_t             expected_q[$];
        int                        errors;

        function new();
            own_addr = '0;
            cost_limit = 8'd16;
            errors = 0;
        endfunction

        function void write_config(logic idx, logic [rtlu_pkg::ADDR_W-1:0] val);
            if (idx == rtlu_pkg::CFG_OWN_ADDRESS)
                own_addr = val;
            else
                cost_limit = val;
        endfunction

        function int first_free();
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (!entry_used[i])
                    return i;
            return -1;
        endfunction

        function void store_route(int s, bit [rtlu_pkg::ADDR_W-1:0] dst,
                                  bit [rtlu_pkg::ADDR_W-1:0] hop,
                                  bit [rtlu_pkg::COST_W-1:0] cost);
            entry_used[s] = 1'b1;
            entry_dst[s] = dst;
            entry_hop[s] = hop;
            entry_cost[s] = cost;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Runs one accepted transaction through the shadow table.
        function void note_request(route_request_t r);
            route_result_t                 res;
            logic [rtlu_pkg::STATUS_W-1:0] st;
            int                            s;
            s = -1;
            for (int i = 0; i < TABLE_ENTRIES && s < 0; i++)
                if (entry_used[i] && entry_dst[i] == r.destination)
                    s = i;

            if (r.command == rtlu_pkg::CMD_LOOKUP)
            begin
                st = (s >= 0) ? rtlu_pkg::ST_FOUND : rtlu_pkg::ST_NOT_FOUND;
            end
            else if (r.destination == own_addr)
            begin
                // self route: hop and cost offered are ignored
                if (s < 0)
                    s = first_free();
                if (s >= 0)
                begin
                    store_route(s, own_addr, own_addr, '0);
                    st = rtlu_pkg::ST_SELF;
                end
                else
                    st = rtlu_pkg::ST_FULL;
            end
            else if (s < 0)
            begin
                s = first_free();
                if (s >= 0)
                begin
                    store_route(s, r.destination, r.via_hop, r.path_cost);
                    st = rtlu_pkg::ST_NEW;
                end
                else
                    st = rtlu_pkg::ST_FULL;
            end
            else if (entry_hop[s] != r.via_hop || entry_cost[s] != r.path_cost)
            begin
                if (r.path_cost >= cost_limit)
                begin
                    // hop kept, cost forced to the infinity value
                    entry_used[s] = 1'b0;
                    entry_cost[s] = cost_limit;
                    st = rtlu_pkg::ST_INVALIDATED;
                end
                else
                begin
                    store_route(s, r.destination, r.via_hop, r.path_cost);
                    st = rtlu_pkg::ST_UPDATED;
                end
            end
            else
                st = rtlu_pkg::ST_UNCHANGED;

            res.status = st;
            if (s >= 0)
            begin
                res.slot = rtlu_pkg::SLOT_W'(s);
                res.hop = entry_hop[s];
                res.cost = entry_cost[s];
            end
            else
            begin
                res.slot = '0;
                res.hop = '0;
                res.cost = '0;
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(route_result_t got);
            route_result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: unexpected result status %0d slot %0d hop %0d cost %0d",
                             $time, got.status, got.slot, got.hop, got.cost);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.slot !== want.slot ||
                got.hop !== want.hop || got.cost !== want.cost)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: mismatch exp status %0d slot %0d hop %0d cost %0d, %s",
                             $time, want.status, want.slot, want.hop, want.cost,
                             $sformatf("got %0d %0d %0d %0d",
                                       got.status, got.slot, got.hop, got.cost));
            end
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic                          cfg_index = rtlu_pkg::CFG_OWN_ADDRESS;
    logic [rtlu_pkg::ADDR_W-1:0]   cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic                          command = rtlu_pkg::CMD_UPDATE;
    logic [rtlu_pkg::ADDR_W-1:0]   destination = '0;
    logic [rtlu_pkg::ADDR_W-1:0]   via_hop = '0;
    logic [rtlu_pkg::COST_W-1:0]   path_cost = '0;
    logic [rtlu_pkg::NOW_W-1:0]    now_time = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [rtlu_pkg::STATUS_W-1:0] status;
    logic [rtlu_pkg::SLOT_W-1:0]   slot;
    logic [rtlu_pkg::ADDR_W-1:0]   route_next_hop;
    logic [rtlu_pkg::COST_W-1:0]   route_cost;

    route_scoreboard board = new();

    // idling knobs, changed per phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // long receiver hold-off, owned by its own process
    logic holding = 1'b0;
    event hold_start;
    int   cycles = 0;

    // last hop and cost offered per destination, so repeats hit "unchanged"
    bit [rtlu_pkg::ADDR_W-1:0] offered_hop  [256];
    bit [rtlu_pkg::COST_W-1:0] offered_cost [256];

    routing_table_update_lookup_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .TIME_BITS(TIME_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .destination(destination),
        .via_hop(via_hop),
        .path_cost(path_cost),
        .now_time(now_time),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .slot(slot),
        .route_next_hop(route_next_hop),
        .route_cost(route_cost)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver: random stall per cycle, forced high during a hold-off
    always @(posedge clk)
        out_stall <= holding || ($urandom_range(99) < recv_stall_pct);

    initial
    begin
        forever
        begin
            @(hold_start);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding <= 1'b0;
        end
    end

    // result monitor: a transaction completes on valid with no stall
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result({status, slot, route_next_hop, route_cost});

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     board.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // register write; the extra edge keeps back-to-back writes from
    // dropping and raising cfg_we in one step
    task automatic set_register(input logic idx, input logic [rtlu_pkg::ADDR_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.write_config(idx, val);
        @(posedge clk);
    endtask

    // Offers one transaction, with random idle cycles ahead of it, and
    // returns at the edge where the block takes it.
    task automatic send_request(input logic cmd, input logic [rtlu_pkg::ADDR_W-1:0] dst,
                                input logic [rtlu_pkg::ADDR_W-1:0] hop,
                                input logic [rtlu_pkg::COST_W-1:0] cost,
                                input logic [rtlu_pkg::NOW_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        destination <= dst;
        via_hop <= hop;
        path_cost <= cost;
        now_time <= now;
        do
            @(posedge clk);
        while (in_stall);
        board.note_request({cmd, dst, hop, cost, now});
    endtask

    // Stops offering and waits until every owed result has come back.
    task automatic wait_drained(input int extra);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
        repeat (extra) @(posedge clk);
    endtask

    // Random traffic over a window of destinations. Most updates are
    // well-formed route adverts; about a third repeat the last offer for
    // that destination, a quarter of the fresh costs lie within one of the
    // infinity value, and a few transactions are pure noise.
    task automatic run_random(input int count, input int pool, input int lookup_pct,
                              input int send_pct, input int stall_pct,
                              input int pause_at, input int hold_at);
        logic                        cmd;
        logic [rtlu_pkg::ADDR_W-1:0] dst;
        logic [rtlu_pkg::ADDR_W-1:0] hop;
        logic [rtlu_pkg::COST_W-1:0] cost;
        logic [rtlu_pkg::ADDR_W-1:0] base;
        send_idle_pct = send_pct;
        recv_stall_pct <= stall_pct;
        base = rtlu_pkg::ADDR_W'($urandom);
        for (int n = 0; n < count; n++)
        begin
            if (n == pause_at)
                wait_drained(0);
            if (n == hold_at)
                -> hold_start;
            cmd = ($urandom_range(99) < lookup_pct) ? rtlu_pkg::CMD_LOOKUP
                                                    : rtlu_pkg::CMD_UPDATE;
            if ($urandom_range(99) < 5)
                dst = board.own_addr;
            else
                dst = rtlu_pkg::ADDR_W'(base + $urandom_range(pool - 1));
            if ($urandom_range(99) < 30)
            begin
                hop = offered_hop[dst];
                cost = offered_cost[dst];
            end
            else
            begin
                hop = ($urandom_range(3) == 0) ? rtlu_pkg::ADDR_W'($urandom)
                                               : rtlu_pkg::ADDR_W'($urandom_range(7));
                case ($urandom_range(3))
                    0: cost = rtlu_pkg::COST_W'($urandom);
                    1: cost = rtlu_pkg::COST_W'(board.cost_limit + $urandom_range(2) - 1);
                    default: cost = rtlu_pkg::COST_W'($urandom_range(15));
                endcase
            end
            if ($urandom_range(99) < 3)
            begin
                cmd = 1'($urandom);
                dst = rtlu_pkg::ADDR_W'($urandom);
                hop = rtlu_pkg::ADDR_W'($urandom);
                cost = rtlu_pkg::COST_W'($urandom);
            end
            if (cmd == rtlu_pkg::CMD_UPDATE)
            begin
                offered_hop[dst] = hop;
                offered_cost[dst] = cost;
            end
            send_request(cmd, dst, hop, cost, $urandom);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset config: own address 0, infinity 16
        // empty table, new route, same offer, hop change, cost change, cost at infinity
        send_request(rtlu_pkg::CMD_LOOKUP, 8'h00, 8'h00, 8'h00, 32'h0000_0000);
        send_request(rtlu_pkg::CMD_UPDATE, 8'h05, 8'h07, 8'h03, 32'h0000_0001);
        send_request(rtlu_pkg::CMD_UPDATE, 8'h05, 8'h07, 8'h03, 32'h0000_0002);
        send_request(rtlu_pkg::CMD_UPDATE, 8'h05, 8'h08, 8'h03, 32'h0000_0003);
        send_request(rtlu_pkg::CMD_UPDATE, 8'h05, 8'h08, 8'h04, 32'h0000_0004);
        send_request(rtlu_pkg::CMD_UPDATE, 8'h05, 8'h08, 8'h10, 32'h0000_0005);
        // gone after that
        send_request(rtlu_pkg::CMD_LOOKUP, 8'h05, 8'h00, 8'h00, 32'h0000_0006);
        // self route, then self refresh
        send_request(rtlu_pkg::CMD_UPDATE, 8'h00, 8'h63, 8'hC8, 32'h0000_0007);
        send_request(rtlu_pkg::CMD_UPDATE, 8'h00, 8'h00, 8'h00, 32'h0000_0008);
        send_request(rtlu_pkg::CMD_LOOKUP, 8'h00, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        // new takes any cost
        send_request(rtlu_pkg::CMD_UPDATE, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        send_request(rtlu_pkg::CMD_UPDATE, 8'hFF, 8'hFF, 8'h00, 32'hFFFF_FFFE);
        send_request(rtlu_pkg::CMD_LOOKUP, 8'hFF, 8'h00, 8'h00, 32'h0000_0000);
        // just below infinity
        send_request(rtlu_pkg::CMD_UPDATE, 8'h01, 8'h00, 8'h0F, 32'h8000_0000);
        send_request(rtlu_pkg::CMD_UPDATE, 8'h01, 8'h00, 8'hFF, 32'h7FFF_FFFF);
        wait_drained(SETTLE_CYCLES);

        // top extremes of both registers
        // known slot turns self, then the old self route changes
        set_register(rtlu_pkg::CFG_OWN_ADDRESS, 8'hFF);
        set_register(rtlu_pkg::CFG_INFINITE_COST, 8'hFF);
        send_request(rtlu_pkg::CMD_UPDATE, 8'hFF, 8'h03, 8'h09, 32'h1234_5678);
        send_request(rtlu_pkg::CMD_UPDATE, 8'h00, 8'h01, 8'h01, 32'h0000_0010);
        send_request(rtlu_pkg::CMD_UPDATE, 8'h00, 8'h01, 8'hFF, 32'h0000_0011);
        wait_drained(SETTLE_CYCLES);

        // infinity of zero: any change invalidates
        set_register(rtlu_pkg::CFG_OWN_ADDRESS, 8'h80);
        set_register(rtlu_pkg::CFG_INFINITE_COST, 8'h00);
        send_request(rtlu_pkg::CMD_UPDATE, 8'hFF, 8'h04, 8'h00, 32'hAAAA_5555);
        send_request(rtlu_pkg::CMD_UPDATE, 8'h20, 8'h01, 8'h00, 32'h5555_AAAA);
        send_request(rtlu_pkg::CMD_UPDATE, 8'h20, 8'h01, 8'h00, 32'h0F0F_F0F0);
        send_request(rtlu_pkg::CMD_LOOKUP, 8'h80, 8'h00, 8'h00, 32'hF0F0_0F0F);
        send_request(rtlu_pkg::CMD_UPDATE, 8'h80, 8'h11, 8'h22, 32'h0000_0100);
        wait_drained(SETTLE_CYCLES);

        // narrow window, lots of matches, no idling
        set_register(rtlu_pkg::CFG_OWN_ADDRESS, 8'h00);
        set_register(rtlu_pkg::CFG_INFINITE_COST, 8'd16);
        run_random(250, 24, 25, 0, 0, -1, -1);
        wait_drained(SETTLE_CYCLES);

        // full address range, infinity at max: fills the table; sender pauses midway
        set_register(rtlu_pkg::CFG_OWN_ADDRESS, 8'hFF);
        set_register(rtlu_pkg::CFG_INFINITE_COST, 8'hFF);
        run_random(300, 256, 10, 45, 0, 150, -1);
        wait_drained(SETTLE_CYCLES);

        // infinity 1 empties slots again; long receiver hold-off backs up the input
        set_register(rtlu_pkg::CFG_OWN_ADDRESS, rtlu_pkg::ADDR_W'($urandom));
        set_register(rtlu_pkg::CFG_INFINITE_COST, 8'd1);
        run_random(300, 256, 20, 0, 45, -1, 100);
        wait_drained(SETTLE_CYCLES);

        set_register(rtlu_pkg::CFG_OWN_ADDRESS, 8'h00);
        set_register(rtlu_pkg::CFG_INFINITE_COST, 8'h00);
        run_random(200, 48, 20, 17, 17, -1, -1);
        wait_drained(SETTLE_CYCLES);

        set_register(rtlu_pkg::CFG_OWN_ADDRESS, rtlu_pkg::ADDR_W'($urandom));
        set_register(rtlu_pkg::CFG_INFINITE_COST, rtlu_pkg::COST_W'($urandom_range(255, 1)));
        run_random(350, 40, 30, 0, 0, -1, -1);
        wait_drained(SETTLE_CYCLES);

        set_register(rtlu_pkg::CFG_INFINITE_COST, 8'd16);
        set_register(rtlu_pkg::CFG_OWN_ADDRESS, rtlu_pkg::ADDR_W'($urandom));
        run_random(350, 256, 15, 17, 17, -1, -1);
        wait_drained(SETTLE_CYCLES);

        if (board.errors == 0 && board.pending() == 0)
            $display("Simulation PASSED");
        else
        begin
            $display("%0d mismatches, %0d results outstanding", board.errors, board.pending());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
